>>> design/ncpc_pkg.sv
package ncpc_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int CMP_BITS = 32;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd2500;
    localparam logic [4:0]  HOUR_MAX       = 5'd23;
    localparam logic [5:0]  MINUTE_MAX     = 6'd59;
    localparam logic [4:0]  HOUR_NOON      = 5'd12;

    localparam logic MODE_POLL   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        VIEW_ALL     = 2'd0,
        VIEW_HOURS   = 2'd1,
        VIEW_MINUTES = 2'd2,
        VIEW_SECONDS = 2'd3
    } view_t;

    typedef enum logic [1:0] {
        REG_SECONDS = 2'd0,
        REG_MINUTES = 2'd1,
        REG_HOURS   = 2'd2
    } clk_reg_t;

    typedef struct packed {
        logic [7:0] tube1;
        logic [7:0] tube2;
        logic [7:0] tube3;
        logic [7:0] tube4;
        logic       pm;
    } disp_t;

    localparam logic [7:0] DIGIT_ROWS [0:9][0:3] = '{
        '{8'd6,   8'd96,  8'd6,   8'd6},
        '{8'd34,  8'd68,  8'd34,  8'd34},
        '{8'd130, 8'd65,  8'd130, 8'd130},
        '{8'd192, 8'd3,   8'd192, 8'd192},
        '{8'd96,  8'd6,   8'd96,  8'd96},
        '{8'd80,  8'd10,  8'd80,  8'd80},
        '{8'd72,  8'd18,  8'd72,  8'd72},
        '{8'd68,  8'd34,  8'd68,  8'd68},
        '{8'd65,  8'd130, 8'd65,  8'd65},
        '{8'd3,   8'd192, 8'd3,   8'd3}
    };

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        begin
            if (v >= 6'd60)
                t = 3'd6;
            else if (v >= 6'd50)
                t = 3'd5;
            else if (v >= 6'd40)
                t = 3'd4;
            else if (v >= 6'd30)
                t = 3'd3;
            else if (v >= 6'd20)
                t = 3'd2;
            else if (v >= 6'd10)
                t = 3'd1;
            else
                t = 3'd0;
            return t;
        end
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] tens_x10;
        logic [5:0] rem;
        begin
            tens_x10 = {3'b000, tens_of(v)} * 6'd10;
            rem      = v - tens_x10;
            return rem[3:0];
        end
    endfunction

    function automatic logic [6:0] to_bcd(input logic [5:0] v);
        begin
            return {tens_of(v), units_of(v)};
        end
    endfunction

    function automatic logic [7:0] digit_pattern(input logic [3:0] digit,
                                                 input logic [1:0] tube);
        logic [7:0] p;
        begin
            if (digit > 4'd9)
                p = 8'd0;
            else
                p = DIGIT_ROWS[digit][tube];
            return p;
        end
    endfunction

endpackage

>>> design/ncpc_display.sv
module ncpc_display
    import ncpc_pkg::*;
(
    input  view_t      view,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [5:0] second,
    input  logic       hour_format,
    input  logic       pm_prev,
    output disp_t      disp
);

    logic [4:0] hour_shown;
    logic       hour_pm;
    logic [7:0] hour_tens_pat;
    logic [7:0] hour_units_pat;
    logic [5:0] low_value;
    logic [7:0] low_tens_pat;
    logic [7:0] low_units_pat;

    always_comb
    begin
        hour_shown = hour;
        hour_pm    = 1'b0;
        if (!hour_format)
        begin
            hour_pm = (hour >= HOUR_NOON);
            if (hour > HOUR_NOON)
                hour_shown = hour - HOUR_NOON;
            if (hour == 5'd0)
            begin
                hour_pm    = 1'b0;
                hour_shown = HOUR_NOON;
            end
        end
    end

    assign hour_tens_pat  = digit_pattern({1'b0, tens_of({1'b0, hour_shown})}, 2'd0);
    assign hour_units_pat = digit_pattern(units_of({1'b0, hour_shown}), 2'd1);

    assign low_value      = (view == VIEW_SECONDS) ? second : minute;
    assign low_tens_pat   = digit_pattern({1'b0, tens_of(low_value)}, 2'd2);
    assign low_units_pat  = digit_pattern(units_of(low_value), 2'd3);

    always_comb
    begin
        unique case (view)
            VIEW_ALL:
            begin
                disp = '{hour_tens_pat, hour_units_pat, low_tens_pat, low_units_pat, hour_pm};
            end
            VIEW_HOURS:
            begin
                disp = '{hour_tens_pat, hour_units_pat, 8'd0, 8'd0, hour_pm};
            end
            default:
            begin
                disp = '{8'd0, 8'd0, low_tens_pat, low_units_pat, pm_prev};
            end
        endcase
    end

endmodule

>>> design/nixie_clock_panel_controller_top.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------
// s_*      | in        | s_tvalid/s_tready  | s_tuser mode, s_tdata buttons + sample
// m_*      | out       | m_tvalid/m_tready  | m_tdata tubes, lamp, write, view
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_data debounce_ticks
//
// One item per cycle unless stalled; each result shows the cycle after its item is taken.
// State updates at the accepting edge, so the next item sees it at once.
// The single output register stalls input only while full and m_tready is low.
// cfg_ready is always high. Reset clears state except m_tdata; debounce_ticks resets to 2500.
module nixie_clock_panel_controller_top
    import ncpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] mode
    input  logic [23:0] s_tdata,   // [0] button_up_n, [1] button_down_n, [6:2] sample_hour,
                                   // [12:7] sample_minute, [18:13] sample_second, [23:19] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] tube1_pins, [15:8] tube2_pins, [23:16] tube3_pins,
                                   // [31:24] tube4_pins, [32] pm_lamp, [33] write_valid,
                                   // [35:34] write_register, [42:36] write_value,
                                   // [44:43] view_step, [47:45] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]             debounce_reg;
    logic [4:0]              hour_reg, hour_next;
    logic [5:0]              minute_reg, minute_next;
    logic [5:0]              second_reg, second_next;
    view_t                   menu_reg, menu_next;
    logic                    format_reg, format_next;
    logic [COUNTER_BITS-1:0] count_reg, count_next;
    logic                    latched_reg, latched_next;
    logic                    pm_reg;
    logic                    out_valid_reg;
    logic [47:0]             out_data_reg, out_data_next;

    logic                    accept;
    logic                    up_pressed;
    logic                    down_pressed;
    logic [COUNTER_BITS-1:0] count_inc;
    logic                    wr_valid;
    clk_reg_t                wr_reg;
    logic [6:0]              wr_value;
    disp_t                   disp;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign up_pressed   = !s_tdata[0];
    assign down_pressed = !s_tdata[1];
    assign count_inc    = count_reg + COUNTER_BITS'(1);

    always_comb
    begin
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        menu_next    = menu_reg;
        format_next  = format_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        wr_valid     = 1'b0;
        wr_reg       = REG_SECONDS;
        wr_value     = 7'd0;
        if (s_tuser == MODE_SAMPLE)
        begin
            hour_next   = s_tdata[6:2];
            minute_next = s_tdata[12:7];
            second_next = s_tdata[18:13];
        end
        else if (up_pressed || down_pressed)
        begin
            count_next = count_inc;
            if ((CMP_BITS'(count_inc) == CMP_BITS'(debounce_reg)) && !latched_reg)
            begin
                if (up_pressed && down_pressed)
                begin
                    menu_next = view_t'(menu_reg + 2'd1);
                end
                else
                begin
                    unique case (menu_reg)
                        VIEW_ALL:
                        begin
                            format_next = !format_reg;
                        end
                        VIEW_HOURS:
                        begin
                            if (up_pressed)
                                hour_next = (hour_reg < HOUR_MAX) ? hour_reg + 5'd1 : 5'd0;
                            else
                                hour_next = (hour_reg > 5'd0) ? hour_reg - 5'd1 : HOUR_MAX;
                            wr_valid = 1'b1;
                            wr_reg   = REG_HOURS;
                            wr_value = to_bcd({1'b0, hour_next});
                        end
                        VIEW_MINUTES:
                        begin
                            if (up_pressed)
                                minute_next = (minute_reg < MINUTE_MAX) ?
                                              minute_reg + 6'd1 : 6'd0;
                            else
                                minute_next = (minute_reg > 6'd0) ?
                                              minute_reg - 6'd1 : MINUTE_MAX;
                            wr_valid = 1'b1;
                            wr_reg   = REG_MINUTES;
                            wr_value = to_bcd(minute_next);
                        end
                        VIEW_SECONDS:
                        begin
                            second_next = 6'd0;
                            wr_valid    = 1'b1;
                            wr_reg      = REG_SECONDS;
                            wr_value    = 7'd0;
                        end
                    endcase
                end
                latched_next = 1'b1;
                count_next   = '0;
            end
        end
        else
        begin
            count_next   = '0;
            latched_next = 1'b0;
        end
    end

    ncpc_display u_display (
        .view        (menu_next),
        .hour        (hour_next),
        .minute      (minute_next),
        .second      (second_next),
        .hour_format (format_next),
        .pm_prev     (pm_reg),
        .disp        (disp)
    );

    assign out_data_next = {3'b000, menu_next, wr_value, wr_reg, wr_valid, disp.pm,
                            disp.tube4, disp.tube3, disp.tube2, disp.tube1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            menu_reg      <= VIEW_ALL;
            format_reg    <= 1'b0;
            count_reg     <= '0;
            latched_reg   <= 1'b0;
            pm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                debounce_reg <= cfg_data;
            if (accept)
            begin
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                menu_reg    <= menu_next;
                format_reg  <= format_next;
                count_reg   <= count_next;
                latched_reg <= latched_next;
                pm_reg      <= disp.pm;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    a_write_not_in_all_view: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[44:43] != VIEW_ALL))
        else $error("register write reported in the all-digits view");

    a_write_register_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[35:34] != 2'd3))
        else $error("register write names an unknown clock register");

    a_blank_hour_tubes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[44:43] == VIEW_MINUTES || m_tdata[44:43] == VIEW_SECONDS))
        |-> (m_tdata[15:0] == 16'd0))
        else $error("hour tubes lit in a minutes or seconds view");

    a_latch_clears_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(latched_reg) |-> $past(accept && s_tuser == MODE_POLL && s_tdata[0] && s_tdata[1]))
        else $error("press latch cleared without a release poll");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(menu_reg) && $stable(count_reg) && $stable(hour_reg)))
        else $error("state changed without an accepted item");

endmodule
